/* rtl/tgad_pkg.sv */
package tgad_pkg;

	localparam int HDR_LEN = 18;
	localparam int HDR_CW  = $clog2(HDR_LEN);
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int OUT_DW  = 88;

	typedef enum logic [1:0] {
		KIND_HDR   = 2'd0,
		KIND_PAL   = 2'd1,
		KIND_PIXEL = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_TYPE   = 3'd1,
		ERR_MAP_ORIGIN = 3'd2,
		ERR_MAP_DEPTH  = 3'd3,
		ERR_PIX_DEPTH  = 3'd4,
		ERR_MAP_LONG   = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		ALPHA_NONE   = 2'd0,
		ALPHA_BYTE   = 2'd1,
		ALPHA_OPAQUE = 2'd2
	} alpha_src_t;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_SKIP    = 6'b000010,
		PH_PALETTE = 6'b000100,
		PH_PIXELS  = 6'b001000,
		PH_DONE    = 6'b010000,
		PH_ERROR   = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [15:0] pos_x;
		logic [15:0] pos_row;
		logic        flip;
		logic [15:0] height;
		logic [31:0] color;
		alpha_src_t  alpha_src;
		logic [7:0]  color_index;
		logic [5:0]  pixel_depth;
		err_t        error_code;
		logic        last;
	} tgad_rec_t;

endpackage

/* rtl/tga_uncompressed_decoder_top.sv */
// TGA decoder for uncompressed colour-mapped and true-colour images, fed one file byte per
// beat with tuser marking the first byte of a file. It takes one byte every cycle while the
// queue has room and emits at most one result per byte: the header summary, each palette
// entry with its index, then each pixel (RGBA or palette index) with its column and output
// row, or a single error. A byte is parsed in the cycle it is accepted and its result
// enters a four-beat queue at that edge; the output register takes it from the queue when
// the output is empty or its beat is taken. While the output side stalls, the queue holds
// four results behind the one waiting at the output before input stops. Sustained rate:
// one byte per cycle while the queue has room.
module tga_uncompressed_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // start_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pos_x[15:0], pos_row[31:16], red[39:32], green[47:40], blue[55:48], alpha[63:56],
	// color_index[71:64], pixel_depth[77:72], error_code[80:78], zero[87:81]
	output logic [87:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast
);
	import tgad_pkg::*;

	tgad_rec_t push_rec, pop_rec;
	logic      push, full, pop, empty;

	tgad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_sof   (s_axis_tuser),
		.q_full   (full),
		.q_push   (push),
		.q_rec    (push_rec)
	);

	tgad_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_rec),
		.full   (full),
		.pop    (pop),
		.dout   (pop_rec),
		.empty  (empty)
	);

	tgad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rec     (pop_rec),
		.q_empty   (empty),
		.q_pop     (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

/* rtl/tgad_front.sv */
module tgad_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_sof,
	input  logic                q_full,
	output logic                q_push,
	output tgad_pkg::tgad_rec_t q_rec
);
	import tgad_pkg::*;

	phase_t             phase_q;
	logic [7:0]         hdr_q [HDR_LEN];
	logic [HDR_CW-1:0]  hcnt_q;
	logic [7:0]         skip_q;
	logic [15:0]        ent_q;
	logic [1:0]         bii_q;
	logic [23:0]        part_q;
	logic [15:0]        col_q;
	logic [15:0]        line_q;

	phase_t             ph, ph_n;
	logic [HDR_CW-1:0]  hc, hc_n;
	logic [7:0]         sk, sk_n;
	logic [15:0]        ent, ent_n;
	logic [1:0]         bii, bii_n;
	logic [23:0]        part, part_n, part_or;
	logic [15:0]        col, col_n;
	logic [15:0]        line, line_n;
	logic               acc;
	tgad_rec_t          rec;
	logic               push;

	logic               has_map, has_pix, has_ent, per4, item_done;
	logic [15:0]        origin, mlen, img_w, img_h;
	err_t               err;
	phase_t             after_hdr, after_skip, after_pal;
	logic [16:0]        col_inc, line_inc;
	logic               wrap, end_img;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign q_push   = acc && push;
	assign q_rec    = rec;

	assign origin  = {hdr_q[4], hdr_q[3]};
	assign mlen    = {hdr_q[6], hdr_q[5]};
	assign img_w   = {hdr_q[13], hdr_q[12]};
	assign img_h   = {hdr_q[15], hdr_q[14]};
	assign has_map = hdr_q[1] != 8'd0;
	assign has_pix = (img_w != 16'd0) && (img_h != 16'd0);
	assign has_ent = has_map && (mlen != 16'd0);

	always_comb begin
		if (hdr_q[2] != 8'd1 && hdr_q[2] != 8'd2) begin
			err = ERR_BAD_TYPE;
		end else if (has_map) begin
			if (origin != 16'd0) begin
				err = ERR_MAP_ORIGIN;
			end else if (hdr_q[7] != 8'd24 && hdr_q[7] != 8'd32) begin
				err = ERR_MAP_DEPTH;
			end else if (mlen > 16'd256) begin
				err = ERR_MAP_LONG;
			end else begin
				err = ERR_NONE;
			end
		end else if (hdr_q[16] != 8'd24 && hdr_q[16] != 8'd32) begin
			err = ERR_PIX_DEPTH;
		end else begin
			err = ERR_NONE;
		end
	end

	always_comb begin
		after_pal  = has_pix ? PH_PIXELS : PH_DONE;
		after_skip = has_ent ? PH_PALETTE : after_pal;
		after_hdr  = (hdr_q[0] != 8'd0) ? PH_SKIP : after_skip;
	end

	always_comb begin
		ph   = in_sof ? PH_HEADER : phase_q;
		hc   = in_sof ? '0 : hcnt_q;
		sk   = in_sof ? '0 : skip_q;
		ent  = in_sof ? '0 : ent_q;
		bii  = in_sof ? '0 : bii_q;
		part = in_sof ? '0 : part_q;
		col  = in_sof ? '0 : col_q;
		line = in_sof ? '0 : line_q;

		per4 = (ph == PH_PALETTE) ? (hdr_q[7] == 8'd32) : (hdr_q[16] == 8'd32);
		case (bii)
			2'd0: part_or = part | {16'd0, in_byte};
			2'd1: part_or = part | {8'd0, in_byte, 8'd0};
			2'd2: part_or = part | {in_byte, 16'd0};
			default: part_or = part;
		endcase
		item_done = per4 ? (bii == 2'd3) : (bii == 2'd2);

		col_inc  = {1'b0, col} + 17'd1;
		line_inc = {1'b0, line} + 17'd1;
		wrap     = col_inc >= {1'b0, img_w};
		end_img  = wrap && (line_inc >= {1'b0, img_h});

		ph_n   = ph;
		hc_n   = hc;
		sk_n   = sk;
		ent_n  = ent;
		bii_n  = bii;
		part_n = part;
		col_n  = col;
		line_n = line;
		rec    = '0;
		push   = 1'b0;

		case (ph)
			PH_HEADER: begin
				if (hc == HDR_CW'(HDR_LEN - 1)) begin
					push   = 1'b1;
					hc_n   = '0;
					sk_n   = '0;
					ent_n  = '0;
					bii_n  = '0;
					part_n = '0;
					col_n  = '0;
					line_n = '0;
					if (err != ERR_NONE) begin
						rec.kind       = KIND_ERR;
						rec.error_code = err;
						rec.last       = 1'b1;
						ph_n           = PH_ERROR;
					end else begin
						rec.kind    = KIND_HDR;
						rec.pos_x   = img_w;
						rec.pos_row = img_h;
						if (has_map) begin
							rec.pixel_depth = (mlen <= 16'd16) ? 6'd4 : 6'd8;
						end else begin
							rec.pixel_depth = 6'd32;
						end
						rec.last = !has_ent && !has_pix;
						ph_n     = after_hdr;
					end
				end else begin
					hc_n = hc + HDR_CW'(1);
				end
			end
			PH_SKIP: begin
				sk_n = sk + 8'd1;
				if (sk_n >= hdr_q[0]) begin
					ph_n = after_skip;
				end
			end
			PH_PALETTE: begin
				if (item_done) begin
					push          = 1'b1;
					rec.kind      = KIND_PAL;
					rec.pos_x     = ent;
					rec.color     = {in_byte, part_or};
					rec.alpha_src = per4 ? ALPHA_BYTE : ALPHA_OPAQUE;
					bii_n         = '0;
					part_n        = '0;
					ent_n         = ent + 16'd1;
					if (ent_n >= mlen) begin
						ph_n     = after_pal;
						rec.last = !has_pix;
					end
				end else begin
					bii_n  = bii + 2'd1;
					part_n = part_or;
				end
			end
			PH_PIXELS: begin
				rec.kind    = KIND_PIXEL;
				rec.pos_x   = col;
				rec.pos_row = line;
				rec.flip    = !hdr_q[17][5];
				rec.height  = img_h;
				rec.last    = end_img;
				if (has_map) begin
					push            = 1'b1;
					rec.color_index = in_byte;
				end else if (item_done) begin
					push          = 1'b1;
					rec.color     = {in_byte, part_or};
					rec.alpha_src = per4 ? ALPHA_BYTE : ALPHA_OPAQUE;
					bii_n         = '0;
					part_n        = '0;
				end else begin
					bii_n  = bii + 2'd1;
					part_n = part_or;
				end
				if (push) begin
					if (wrap) begin
						col_n  = '0;
						line_n = line_inc[15:0];
						if (end_img) begin
							ph_n = PH_DONE;
						end
					end else begin
						col_n = col_inc[15:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			skip_q  <= '0;
			ent_q   <= '0;
			bii_q   <= '0;
			part_q  <= '0;
			col_q   <= '0;
			line_q  <= '0;
		end else if (acc) begin
			phase_q <= ph_n;
			hcnt_q  <= hc_n;
			skip_q  <= sk_n;
			ent_q   <= ent_n;
			bii_q   <= bii_n;
			part_q  <= part_n;
			col_q   <= col_n;
			line_q  <= line_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < HDR_LEN; i++) begin
			if (acc && ph == PH_HEADER && hc == HDR_CW'(i)) begin
				hdr_q[i] <= in_byte;
			end
		end
	end

endmodule

/* rtl/tgad_fifo.sv */
module tgad_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tgad_pkg::tgad_rec_t din,
	output logic                full,
	input  logic                pop,
	output tgad_pkg::tgad_rec_t dout,
	output logic                empty
);
	import tgad_pkg::*;

	tgad_rec_t      mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign full    = cnt_q == (QAW + 1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QAW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QAW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

/* rtl/tgad_back.sv */
module tgad_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tgad_pkg::tgad_rec_t        q_rec,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tgad_pkg::OUT_DW-1:0] out_data,
	output logic [1:0]                 out_kind,
	output logic                       out_last
);
	import tgad_pkg::*;

	logic              valid_q;
	logic [OUT_DW-1:0] data_q;
	logic [1:0]        kind_q;
	logic              last_q;
	logic [15:0]       row;
	logic [7:0]        alpha;
	logic [OUT_DW-1:0] data_n;

	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	always_comb begin
		if (q_rec.kind == KIND_PIXEL && q_rec.flip) begin
			row = q_rec.height - 16'd1 - q_rec.pos_row;
		end else begin
			row = q_rec.pos_row;
		end
		case (q_rec.alpha_src)
			ALPHA_BYTE:   alpha = q_rec.color[31:24];
			ALPHA_OPAQUE: alpha = 8'hFF;
			default:      alpha = 8'h00;
		endcase
		data_n = {7'd0, q_rec.error_code, q_rec.pixel_depth, q_rec.color_index, alpha,
			q_rec.color[7:0], q_rec.color[15:8], q_rec.color[23:16], row, q_rec.pos_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= data_n;
			kind_q <= q_rec.kind;
			last_q <= q_rec.last;
		end
	end

endmodule

/* rtl/tgad_checker.sv */
module tgad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import tgad_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ERR |-> m_axis_tlast)
		else $error("error beat without tlast");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_ERR |-> m_axis_tdata[80:78] == ERR_NONE)
		else $error("error code on a non-error beat");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_PIXEL |-> m_axis_tdata[71:64] == 8'd0)
		else $error("palette index outside a pixel beat");

endmodule

bind tga_uncompressed_decoder_top tgad_checker u_tgad_checker (.*);
